@@ rtl/hybrid_bitmap_word_decoder_top_assert.svh @@
// Assertion macros shared by the decoder checker.
`ifndef HYBRID_BITMAP_WORD_DECODER_TOP_ASSERT_SVH
`define HYBRID_BITMAP_WORD_DECODER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define HBWD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbwd assertion failed");

// next-cycle implication, off during reset
`define HBWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbwd assertion failed");

// next-cycle implication, also checked in reset
`define HBWD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hbwd assertion failed");

`endif

@@ rtl/hbwd_pkg.sv @@
// Types, constants, microcode ROM and field helpers for the bitmap word decoder.
package hbwd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BASE_W = 33;
  localparam int unsigned OFFS_W = 33;
  localparam int unsigned SUM_W  = 35;
  localparam int unsigned CTR_W  = 27;
  localparam int unsigned LIT_W  = 31;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned RUN_W  = 2;
  localparam int unsigned STEP_W = 3;

  localparam logic [POS_W-1:0] CHUNK_BITS = 5'd31;

  typedef logic [STEP_W-1:0] step_t;

  // microprogram addresses
  localparam step_t S_IDLE   = 3'd0;
  localparam step_t S_LIT    = 3'd1;
  localparam step_t S_LITEND = 3'd2;
  localparam step_t S_LEAD   = 3'd3;
  localparam step_t S_MID    = 3'd4;
  localparam step_t S_TRAIL  = 3'd5;
  localparam step_t S_CEND   = 3'd6;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_LIT,
    EMIT_FIELD
  } emit_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_IN_LIT,
    COND_LIT_REST0,
    COND_RUN_DONE,
    COND_ALWAYS
  } cond_t;

  typedef enum logic [1:0] {
    BASE_HOLD,
    BASE_ADD31,
    BASE_ADD_END
  } base_op_t;

  typedef struct packed {
    logic     wait_in;
    emit_t    emit;
    logic     final_run;
    logic     set_mid;
    base_op_t base_op;
    cond_t    cond;
    step_t    jmp;
    step_t    nxt;
  } ucode_t;

  typedef struct packed {
    logic hold;
    logic in_lit;
    logic lit_rest0;
    logic run_done;
  } dp_status_t;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    w.wait_in   = 1'b0;
    w.emit      = EMIT_NONE;
    w.final_run = 1'b0;
    w.set_mid   = 1'b0;
    w.base_op   = BASE_HOLD;
    w.cond      = COND_ALWAYS;
    w.jmp       = S_IDLE;
    w.nxt       = S_IDLE;
    case (pc)
      S_IDLE: begin
        w.wait_in = 1'b1;
        w.cond    = COND_IN_LIT;
        w.jmp     = S_LIT;
        w.nxt     = S_LEAD;
      end
      S_LIT: begin
        w.emit = EMIT_LIT;
        w.cond = COND_LIT_REST0;
        w.jmp  = S_LITEND;
        w.nxt  = S_LIT;
      end
      S_LITEND: begin
        w.base_op = BASE_ADD31;
      end
      S_LEAD: begin
        w.emit = EMIT_FIELD;
        w.cond = COND_RUN_DONE;
        w.jmp  = S_MID;
        w.nxt  = S_LEAD;
      end
      S_MID: begin
        w.set_mid = 1'b1;
        w.cond    = COND_NEVER;
        w.nxt     = S_TRAIL;
      end
      S_TRAIL: begin
        w.emit      = EMIT_FIELD;
        w.final_run = 1'b1;
        w.cond      = COND_RUN_DONE;
        w.jmp       = S_CEND;
        w.nxt       = S_TRAIL;
      end
      S_CEND: begin
        w.base_op = BASE_ADD_END;
      end
      default: begin
        w.cond = COND_ALWAYS;
      end
    endcase
    return w;
  endfunction

  // 5-bit position fields run from bit 26 downward; the sixth lies below bit 0
  function automatic logic [POS_W-1:0] field_at(input logic [WORD_W-1:0] w,
                                                input logic [IDX_W-1:0] idx);
    logic [POS_W-1:0] f;
    case (idx)
      3'd0:    f = w[26:22];
      3'd1:    f = w[21:17];
      3'd2:    f = w[16:12];
      3'd3:    f = w[11:7];
      3'd4:    f = w[6:2];
      default: f = '0;
    endcase
    return f;
  endfunction

  // fill counter takes the bits left under the position fields
  function automatic logic [CTR_W-1:0] counter_of(input logic [WORD_W-1:0] w);
    logic [2:0]       nsum;
    logic [CTR_W-1:0] c;
    nsum = {1'b0, w[30:29]} + {1'b0, w[28:27]};
    case (nsum)
      3'd0:    c = w[26:0];
      3'd1:    c = {5'd0, w[21:0]};
      3'd2:    c = {10'd0, w[16:0]};
      3'd3:    c = {15'd0, w[11:0]};
      3'd4:    c = {20'd0, w[6:0]};
      3'd5:    c = {25'd0, w[1:0]};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/hbwd_sequencer.sv @@
// Microprogram counter, control ROM lookup and branch selection.
module hbwd_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  hbwd_pkg::dp_status_t st,
  output hbwd_pkg::ucode_t   uc
);

  hbwd_pkg::step_t pc_r;
  hbwd_pkg::step_t pc_nxt;
  logic            take;

  assign uc = hbwd_pkg::ucode_rom(pc_r);

  always_comb begin
    case (uc.cond)
      hbwd_pkg::COND_NEVER:     take = 1'b0;
      hbwd_pkg::COND_IN_LIT:    take = st.in_lit;
      hbwd_pkg::COND_LIT_REST0: take = st.lit_rest0;
      hbwd_pkg::COND_RUN_DONE:  take = st.run_done;
      hbwd_pkg::COND_ALWAYS:    take = 1'b1;
      default:                  take = 1'b1;
    endcase
  end

  always_comb begin
    if (st.hold) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = uc.jmp;
    end else begin
      pc_nxt = uc.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= hbwd_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ rtl/hbwd_datapath.sv @@
// Decode datapath: word, base and offset registers, bit scan and output register.
module hbwd_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hbwd_pkg::ucode_t             uc,
  input  logic                         in_valid,
  input  logic [hbwd_pkg::WORD_W-1:0]  in_codeword,
  input  logic                         in_first_word,
  input  logic                         out_stall,
  output hbwd_pkg::dp_status_t         st,
  output logic                         out_valid,
  output logic [hbwd_pkg::WORD_W-1:0]  out_position,
  output logic                         out_last_of_word,
  output logic                         out_overflow
);

  logic [hbwd_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [hbwd_pkg::BASE_W-1:0] base_r, base_nxt;
  logic [hbwd_pkg::OFFS_W-1:0] offset_r, offset_nxt;
  logic [hbwd_pkg::LIT_W-1:0]  mask_r, mask_nxt;
  logic [hbwd_pkg::RUN_W-1:0]  cnt_r, cnt_nxt;
  logic [hbwd_pkg::IDX_W-1:0]  idx_r, idx_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [hbwd_pkg::WORD_W-1:0] pos_r, pos_nxt;
  logic                        last_r, last_nxt;
  logic                        ovf_r, ovf_nxt;

  logic [hbwd_pkg::LIT_W-1:0]  lit_rest;
  logic                        lit_any;
  logic [hbwd_pkg::POS_W-1:0]  low_idx;
  logic [hbwd_pkg::POS_W-1:0]  addend;
  logic [hbwd_pkg::SUM_W-1:0]  pos_sum;
  logic [hbwd_pkg::OFFS_W-1:0] mid_offs;
  logic [hbwd_pkg::OFFS_W-1:0] end_add;
  logic [hbwd_pkg::CTR_W-1:0]  ctr;
  logic [hbwd_pkg::RUN_W-1:0]  n1, n2;
  logic                        out_free;
  logic                        emit_need;
  logic                        emit_last;
  logic                        go;
  logic                        load;

  assign n1 = word_r[30:29];
  assign n2 = word_r[28:27];

  assign lit_any  = |mask_r;
  assign lit_rest = mask_r & (mask_r - hbwd_pkg::LIT_W'(1));

  // lowest set bit of the remaining literal mask
  always_comb begin
    low_idx = '0;
    for (int i = hbwd_pkg::LIT_W - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_idx = hbwd_pkg::POS_W'(i);
      end
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign emit_need = ((uc.emit == hbwd_pkg::EMIT_LIT) && lit_any) ||
                     ((uc.emit == hbwd_pkg::EMIT_FIELD) && (cnt_r != '0));

  assign st.hold      = (uc.wait_in && !in_valid) || (emit_need && !out_free);
  assign st.in_lit    = in_codeword[31];
  assign st.lit_rest0 = (lit_rest == '0);
  assign st.run_done  = !cnt_r[1];

  assign go   = !st.hold;
  assign load = uc.wait_in && in_valid;

  assign addend  = (uc.emit == hbwd_pkg::EMIT_LIT) ? low_idx
                                                   : hbwd_pkg::field_at(word_r, idx_r);
  assign pos_sum = hbwd_pkg::SUM_W'(base_r) + hbwd_pkg::SUM_W'(offset_r) +
                   hbwd_pkg::SUM_W'(addend);

  assign emit_last = (uc.emit == hbwd_pkg::EMIT_LIT) ? (lit_rest == '0)
                   : ((cnt_r == hbwd_pkg::RUN_W'(1)) && (uc.final_run || (n2 == '0)));

  // leading chunk plus 31 * fill counter, done as a shift and subtract
  assign ctr      = hbwd_pkg::counter_of(word_r);
  assign mid_offs = ((n1 != '0) ? hbwd_pkg::OFFS_W'(hbwd_pkg::CHUNK_BITS) : '0) +
                    ((hbwd_pkg::OFFS_W'(ctr) << 5) - hbwd_pkg::OFFS_W'(ctr));
  assign end_add  = offset_r +
                    ((n2 != '0) ? hbwd_pkg::OFFS_W'(hbwd_pkg::CHUNK_BITS) : '0);

  always_comb begin
    word_nxt      = word_r;
    base_nxt      = base_r;
    offset_nxt    = offset_r;
    mask_nxt      = mask_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;

    if (load) begin
      word_nxt   = in_codeword;
      offset_nxt = '0;
      mask_nxt   = in_codeword[30:0];
      cnt_nxt    = in_codeword[30:29];
      idx_nxt    = '0;
      if (in_first_word) begin
        base_nxt = '0;
      end
    end

    if (go) begin
      case (uc.base_op)
        hbwd_pkg::BASE_HOLD:    base_nxt = base_nxt;
        hbwd_pkg::BASE_ADD31:   base_nxt = base_r + hbwd_pkg::BASE_W'(hbwd_pkg::CHUNK_BITS);
        hbwd_pkg::BASE_ADD_END: base_nxt = base_r + hbwd_pkg::BASE_W'(end_add);
        default:                base_nxt = base_nxt;
      endcase
      if (uc.set_mid) begin
        offset_nxt = mid_offs;
        cnt_nxt    = n2;
      end
      if (emit_need) begin
        if (uc.emit == hbwd_pkg::EMIT_LIT) begin
          mask_nxt = lit_rest;
        end else begin
          cnt_nxt = cnt_r - hbwd_pkg::RUN_W'(1);
          idx_nxt = idx_r + hbwd_pkg::IDX_W'(1);
        end
      end
    end

    if (go && emit_need) begin
      out_valid_nxt = 1'b1;
      pos_nxt       = pos_sum[hbwd_pkg::WORD_W-1:0];
      last_nxt      = emit_last;
      ovf_nxt       = |pos_sum[hbwd_pkg::SUM_W-1:hbwd_pkg::WORD_W];
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    offset_r <= offset_nxt;
    mask_r   <= mask_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    last_r   <= last_nxt;
    ovf_r    <= ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_position     = pos_r;
  assign out_last_of_word = last_r;
  assign out_overflow     = ovf_r;

endmodule

@@ rtl/hybrid_bitmap_word_decoder_top.sv @@
// Top level of the word-aligned hybrid bitmap decoder.
// Input channel: one 32-bit codeword per transfer (in_valid / in_stall), with
// in_first_word clearing the running base position before the word decodes.
// Output channel: one set-bit position per transfer (out_valid / out_stall),
// with out_last_of_word on the final position of a codeword and out_overflow
// when the unwrapped position reached 2^32.
// Step sequence, set by the microcode and followed by one output register:
//   literal word:    wait step, literal steps (one per set bit, at least one), literal-end step
//   compressed word: wait step, lead steps, mid step, trail steps, end step
// The first position is registered in the output register from the first emit step.
// One word is in work at a time; in_stall is low only in the wait step, and the
// final position of the previous word may still sit in the output register then.
// Words that hold no set positions produce no output transfer but still move the base.
// Reset (rst_n low, synchronous) clears the base position, the step counter
// and the output valid. When out_stall is high while out_valid is set, the output
// register holds its position and the sequencer waits on its next emit step.
module hybrid_bitmap_word_decoder_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hbwd_pkg::WORD_W-1:0]  in_codeword,
  input  logic                         in_first_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hbwd_pkg::WORD_W-1:0]  out_position,
  output logic                         out_last_of_word,
  output logic                         out_overflow
);

  hbwd_pkg::ucode_t     uc;
  hbwd_pkg::dp_status_t st;

  hbwd_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uc    (uc)
  );

  hbwd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .uc               (uc),
    .in_valid         (in_valid),
    .in_codeword      (in_codeword),
    .in_first_word    (in_first_word),
    .out_stall        (out_stall),
    .st               (st),
    .out_valid        (out_valid),
    .out_position     (out_position),
    .out_last_of_word (out_last_of_word),
    .out_overflow     (out_overflow)
  );

  assign in_stall = !uc.wait_in;

endmodule

@@ rtl/hbwd_checker.sv @@
// Port-level checker for the bitmap word decoder, bound to the top level.
`include "hybrid_bitmap_word_decoder_top_assert.svh"

module hbwd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [hbwd_pkg::WORD_W-1:0]  in_codeword,
  input logic                         in_first_word,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [hbwd_pkg::WORD_W-1:0]  out_position,
  input logic                         out_last_of_word,
  input logic                         out_overflow
);

  logic unused_in;
  assign unused_in = ^{in_codeword, in_first_word, out_overflow};

  `HBWD_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid)

  // one word in work at a time
  `HBWD_ASSERT_NEXT(a_one_word, clk, rst_n, in_valid && !in_stall, in_stall)

  // when ready for a word, any pending position closes the previous word
  `HBWD_ASSERT_IMPL(a_ready_last, clk, rst_n, !in_stall && out_valid, out_last_of_word)

  `HBWD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_position) && $stable(out_last_of_word))

endmodule

bind hybrid_bitmap_word_decoder_top hbwd_checker u_hbwd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_codeword      (in_codeword),
  .in_first_word    (in_first_word),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_position     (out_position),
  .out_last_of_word (out_last_of_word),
  .out_overflow     (out_overflow)
);
